FILE: rtl/core/cdsc_pkg.sv
`default_nettype none

package cdsc_pkg;

  // field widths fixed by the chunk header format
  localparam int unsigned ByteW  = 8;
  localparam int unsigned SizeW  = 10;
  localparam int unsigned SeqW   = 10;
  localparam int unsigned CountW = 8;
  localparam int unsigned PktW   = 11;

  // bit of the first header byte that marks a vital chunk
  localparam int unsigned VitalBit = 6;

  // parser position within the chunk area
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HDR0 = 3'd1,
    PH_HDR1 = 3'd2,
    PH_HDR2 = 3'd3,
    PH_BODY = 3'd4
  } phase_e;

  // result kinds
  typedef enum logic [1:0] {
    K_BYTE   = 2'd0,
    K_EMPTY  = 2'd1,
    K_RESEND = 2'd2,
    K_TRUNC  = 2'd3
  } kind_e;

  // one result beat
  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  data;
    logic [SizeW-1:0]  size;
    logic              first;
    logic              last;
    logic [SeqW-1:0]   seq;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/chunk_deframer_with_sequence_check_unit.sv
`default_nettype none

// Chunk deframer with sequence check. Takes the chunk area of a decompressed
// packet one byte per beat (packet_start marks the first byte and carries the
// packet size and chunk count), parses each chunk header and delivers payload
// bytes with first/last marks, one beat for an empty chunk, a resend request
// for an out-of-order vital chunk and a truncation beat when a header or
// chunk overruns the packet. Old duplicates and everything after a truncation
// or after the last chunk give no beats. One byte is accepted every cycle
// while results are taken; each byte passes an input register, a single parser
// state update and a result register before its result is valid. A result held
// by out_ready_i low stops the parser, and the input register then takes at most
// one more byte.
// seq_check_enable resets to 1 and should only be written while the block is
// idle; with it at 0 every chunk is delivered and the ack counter is frozen.
module chunk_deframer_with_sequence_check_unit #(
  parameter int unsigned SEQ_BITS         = 10,
  parameter int unsigned MAX_PACKET_BYTES = 2047
) (
  input  wire  logic                        clk_i,
  input  wire  logic                        rst_ni,
  // configuration write channel
  input  wire  logic                        cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  logic                        cfg_seq_check_enable_i,
  // input byte channel
  input  wire  logic                        in_valid_i,
  output logic                              in_ready_o,
  input  wire  logic [cdsc_pkg::ByteW-1:0]  data_byte_i,
  input  wire  logic                        packet_start_i,
  input  wire  logic [cdsc_pkg::PktW-1:0]   packet_size_i,
  input  wire  logic [cdsc_pkg::CountW-1:0] chunk_count_i,
  // result channel
  output logic                              out_valid_o,
  input  wire  logic                        out_ready_i,
  output logic [1:0]                        kind_o,
  output logic [cdsc_pkg::ByteW-1:0]        payload_byte_o,
  output logic [cdsc_pkg::SizeW-1:0]        chunk_size_o,
  output logic                              chunk_first_o,
  output logic                              chunk_last_o,
  output logic [cdsc_pkg::SeqW-1:0]         chunk_seq_o
);

  import cdsc_pkg::*;

  localparam int unsigned MaxClip = (MAX_PACKET_BYTES > 2047) ? 2047 : MAX_PACKET_BYTES;
  localparam logic [PktW-1:0]     MaxBytes = PktW'(MaxClip);
  localparam logic [SEQ_BITS-1:0] SeqHalf  = {1'b1, {(SEQ_BITS-1){1'b0}}};

  // configuration register
  logic seq_en_q;

  // input register
  logic              in_vld_q;
  logic [ByteW-1:0]  in_byte_q;
  logic              in_start_q;
  logic [PktW-1:0]   in_psize_q;
  logic [CountW-1:0] in_ccount_q;

  // parser state
  phase_e            phase_q, phase_d;
  logic [SEQ_BITS-1:0] ack_q, ack_d;
  logic [CountW-1:0] cl_q, cl_d;
  logic [PktW-1:0]   bl_q, bl_d;
  logic [ByteW-1:0]  hb0_q, hb0_d;
  logic [ByteW-1:0]  hb1_q, hb1_d;
  logic [SizeW-1:0]  pl_q, pl_d;
  logic              df_q, df_d;
  logic [SeqW-1:0]   cs_q, cs_d;

  // result register
  logic    out_vld_q;
  result_t res_q;
  result_t res;
  logic    has_res;

  logic advance;
  logic fire;

  // parser scratch values
  logic [PktW-1:0]     avail;
  logic [PktW-1:0]     need;
  logic [ByteW-1:0]    hdr_lo;
  logic [SizeW-1:0]    fin_size;
  logic [SizeW-1:0]    body_size;
  logic [SeqW-1:0]     seq_hdr;
  logic [SeqW-1:0]     fin_seq;
  logic                fin_vital;
  logic [SEQ_BITS-1:0] seq_s;
  logic [SEQ_BITS-1:0] seq_exp;
  logic [SEQ_BITS-1:0] seq_diff;
  logic [SizeW-1:0]    pl_dec;
  logic                body_first;
  logic                body_last;

  assign advance     = !out_vld_q || out_ready_i;
  assign fire        = in_vld_q && advance;
  assign in_ready_o  = !in_vld_q || advance;
  assign cfg_ready_o = 1'b1;

  // configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_en_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      seq_en_q <= cfg_seq_check_enable_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q   <= data_byte_i;
      in_start_q  <= packet_start_i;
      in_psize_q  <= packet_size_i;
      in_ccount_q <= chunk_count_i;
    end
  end

  // parser: one state update per byte
  always_comb begin
    phase_d = phase_q;
    ack_d   = ack_q;
    cl_d    = cl_q;
    bl_d    = bl_q;
    hb0_d   = hb0_q;
    hb1_d   = hb1_q;
    pl_d    = pl_q;
    df_d    = df_q;
    cs_d    = cs_q;
    res     = '0;
    res.kind = K_BYTE;
    has_res = 1'b0;

    // packet start reloads the counters
    if (in_start_q) begin
      bl_d    = (in_psize_q > MaxBytes) ? MaxBytes : in_psize_q;
      cl_d    = in_ccount_q;
      pl_d    = '0;
      df_d    = 1'b0;
      cs_d    = '0;
      hb0_d   = '0;
      hb1_d   = '0;
      phase_d = (in_ccount_q != '0) ? PH_HDR0 : PH_IDLE;
    end

    // every byte in a live packet consumes one byte of the packet
    avail = bl_d;
    if (phase_d != PH_IDLE && bl_d != '0) begin
      bl_d = bl_d - 1'b1;
    end

    // header fields
    hdr_lo     = (phase_d == PH_HDR1) ? in_byte_q : hb1_d;
    fin_size   = {hb0_d[5:0], hdr_lo[3:0]};
    body_size  = {hb0_d[5:0], hb1_d[3:0]};
    // upper nibble of the size byte overlaps the low sequence byte
    seq_hdr    = {hb1_d[7:4], 6'b000000} | {2'b00, in_byte_q};
    fin_vital  = (phase_d == PH_HDR2);
    fin_seq    = fin_vital ? seq_hdr : '0;
    need       = in_byte_q[VitalBit] ? PktW'(3) : PktW'(2);
    seq_s      = seq_hdr[SEQ_BITS-1:0];
    seq_exp    = ack_q + 1'b1;
    seq_diff   = ack_q - seq_s;
    pl_dec     = pl_d - 1'b1;
    body_first = (pl_d == body_size);
    body_last  = (pl_dec == '0);

    case (phase_d)
      PH_HDR0: begin
        hb0_d = in_byte_q;
        cs_d  = '0;
        if (avail < need) begin
          // header runs past the packet
          phase_d  = PH_IDLE;
          cl_d     = '0;
          pl_d     = '0;
          df_d     = 1'b0;
          res.kind = K_TRUNC;
          has_res  = 1'b1;
        end else begin
          phase_d = PH_HDR1;
        end
      end
      PH_HDR1, PH_HDR2: begin
        if (phase_d == PH_HDR1) begin
          hb1_d = in_byte_q;
        end
        if (phase_d == PH_HDR1 && hb0_d[VitalBit]) begin
          phase_d = PH_HDR2;
        end else begin
          // header complete
          cs_d = fin_seq;
          cl_d = cl_d - 1'b1;
          if ({1'b0, fin_size} > bl_d) begin
            // chunk runs past the packet
            phase_d  = PH_IDLE;
            cl_d     = '0;
            pl_d     = '0;
            df_d     = 1'b0;
            res.kind = K_TRUNC;
            res.size = fin_size;
            res.seq  = fin_seq;
            has_res  = 1'b1;
          end else begin
            df_d = 1'b1;
            if (fin_vital && seq_en_q) begin
              if (seq_s == seq_exp) begin
                ack_d = seq_exp;
              end else begin
                df_d = 1'b0;
                // outside the back half-window: ask for a resend
                if (seq_diff > SeqHalf) begin
                  res.kind = K_RESEND;
                  res.size = fin_size;
                  res.seq  = fin_seq;
                  has_res  = 1'b1;
                end
              end
            end
            if (fin_size != '0) begin
              pl_d    = fin_size;
              phase_d = PH_BODY;
            end else begin
              pl_d = '0;
              if (df_d) begin
                res.kind  = K_EMPTY;
                res.first = 1'b1;
                res.last  = 1'b1;
                res.seq   = fin_seq;
                has_res   = 1'b1;
              end
              phase_d = (cl_d != '0) ? PH_HDR0 : PH_IDLE;
            end
          end
        end
      end
      PH_BODY: begin
        pl_d = pl_dec;
        if (df_d) begin
          res.kind  = K_BYTE;
          res.data  = in_byte_q;
          res.size  = body_size;
          res.first = body_first;
          res.last  = body_last;
          res.seq   = cs_d;
          has_res   = 1'b1;
        end
        if (body_last) begin
          phase_d = (cl_d != '0) ? PH_HDR0 : PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ack_q   <= '0;
      cl_q    <= '0;
      bl_q    <= '0;
      hb0_q   <= '0;
      hb1_q   <= '0;
      pl_q    <= '0;
      df_q    <= 1'b0;
      cs_q    <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      ack_q   <= ack_d;
      cl_q    <= cl_d;
      bl_q    <= bl_d;
      hb0_q   <= hb0_d;
      hb1_q   <= hb1_d;
      pl_q    <= pl_d;
      df_q    <= df_d;
      cs_q    <= cs_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= fire && has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign kind_o         = res_q.kind;
  assign payload_byte_o = res_q.data;
  assign chunk_size_o   = res_q.size;
  assign chunk_first_o  = res_q.first;
  assign chunk_last_o   = res_q.last;
  assign chunk_seq_o    = res_q.seq;

  // a chunk body always has bytes left to take
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> pl_q != '0)
    else $error("body phase with no payload left");

  // a truncation beat leaves the parser idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && has_res && res.kind == K_TRUNC) |=> phase_q == PH_IDLE)
    else $error("parser not idle after truncation");

  // an empty chunk beat is marked first and last with size zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.kind == K_EMPTY) |->
      (res_q.first && res_q.last && res_q.size == '0))
    else $error("malformed empty chunk beat");

  // resend requests only come from sequence checking
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.kind == K_RESEND) |-> seq_en_q)
    else $error("resend request with sequence check off");

endmodule

`default_nettype wire
